/* hw/rtl/amss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// amss_pkg: shared types and constants of the adaptive MCMC step scaler
// Holds the request and result beat formats, the register indexes and the
// elaboration-time arithmetic that builds the step scale table.
// ----------------------------------------------------------------------------
package amss_pkg;

    typedef struct packed {
        logic        req_type;
        logic [31:0] chain_length;
        logic [31:0] current_first;
        logic [31:0] previous_first;
        logic [3:0]  load_index;
        logic [31:0] load_value;
    } t_amss_in;

    typedef struct packed {
        logic [3:0]  param_index;
        logic [31:0] step_size;
        logic        window_closed;
        logic        last;
    } t_amss_out;

    localparam logic       REQ_ITER = 1'b0;
    localparam logic       REQ_LOAD = 1'b1;

    localparam logic [1:0] CFG_BURNIN = 2'd0;
    localparam logic [1:0] CFG_SINGLE = 2'd1;
    localparam logic [1:0] CFG_ACTIVE = 2'd2;

    localparam int          CNT_W     = 5;
    localparam logic [31:0] UNITY_Q16 = 32'h0001_0000;

    localparam logic [63:0] LN2_Q30 = 64'd744261118;
    localparam logic [63:0] C0 = ((64'd2515517 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] C1 = ((64'd802853 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] C2 = ((64'd10328 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D0 = ((64'd1432788 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D1 = ((64'd189269 << 30) + 64'd500000) / 64'd1000000;
    localparam logic [63:0] D2 = ((64'd1308 << 30) + 64'd500000) / 64'd1000000;

    // Shift-subtract division, used only while the scale table is built.
    function automatic logic [63:0] udiv64(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, b}) begin
                rem    = rem - {1'b0, b};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // log2 in Q.30: integer part from the top set bit, fraction by squaring.
    function automatic logic [63:0] log2_q30(input logic [63:0] n);
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] frac;
        e    = '0;
        frac = '0;
        if (n == 64'd0) begin
            return 64'd0;
        end
        for (int j = 0; j < 29; j++) begin
            if ((n >> (e + 64'd1)) != 64'd0) begin
                e = e + 64'd1;
            end
        end
        m = n << (64'd30 - e);
        for (int j = 0; j < 30; j++) begin
            m    = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd2 << 30)) begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (e << 30) | frac;
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = '0;
        b = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (b > v) begin
                b = b >> 2;
            end
        end
        for (int j = 0; j < 32; j++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // Rational approximation of the upper normal quantile for p = num/den.
    function automatic logic signed [63:0] neg_quantile(input logic [63:0] num,
                                                        input logic [63:0] den);
        logic [63:0] diff;
        logic [63:0] x;
        logic [63:0] t;
        logic [63:0] nu;
        logic [63:0] de;
        logic [63:0] q;
        diff = log2_q30(den) - log2_q30(num);
        x    = (diff * LN2_Q30) >> 29;
        t    = isqrt64(x << 30);
        nu   = ((C2 * t) >> 30) + C1;
        nu   = ((nu * t) >> 30) + C0;
        de   = ((D2 * t) >> 30) + D1;
        de   = ((de * t) >> 30) + D0;
        de   = ((de * t) >> 30) + (64'd1 << 30);
        q    = udiv64(nu << 30, de);
        return $signed(t) - $signed(q);
    endfunction

    // Q16.16 scale for k acceptances in a window of the given length.
    function automatic logic [31:0] scale_entry(input logic [63:0] k,
                                                input logic [63:0] window,
                                                input logic        single);
        logic signed [63:0] gt;
        logic signed [63:0] gr;
        logic [63:0]        s;
        gt = single ? neg_quantile(64'd11, 64'd50) : neg_quantile(64'd117, 64'd1000);
        gr = neg_quantile(k, window << 1);
        if (gt <= 64'sd0) begin
            return 32'd0;
        end
        if (gr <= 64'sd0) begin
            return 32'hFFFF_FFFF;
        end
        s = udiv64($unsigned(gt) << 16, $unsigned(gr));
        return (s > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/amss_step_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// amss_step_mem: step size memory
// One write port and one read port; read data is registered and held while
// the read enable is low.
// ----------------------------------------------------------------------------
module amss_step_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [31:0]   i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic [31:0]        o_rdata
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hw/rtl/amss_scale_rom.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// amss_scale_rom: step scale table
// Two tables built at elaboration, one per target acceptance rate, indexed
// by the clamped acceptance count. Entry zero holds the value for one
// acceptance. The output is registered; outside a window close it is unity.
// ----------------------------------------------------------------------------
module amss_scale_rom
    import amss_pkg::*;
#(
    parameter int WINDOW = 64,
    parameter int KW     = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic          i_closed,
    input  wire logic          i_single,
    input  wire logic [KW-1:0] i_kidx,
    output logic [31:0]        o_scale
);

    logic [31:0] w_rom_hi [WINDOW];
    logic [31:0] w_rom_lo [WINDOW];
    logic [31:0] r_scale;

    for (genvar g = 0; g < WINDOW; g++) begin : g_rom
        localparam logic [63:0] K_VAL = (g == 0) ? 64'd1 : 64'(g);
        localparam logic [31:0] S_HI  = scale_entry(K_VAL, 64'(WINDOW), 1'b1);
        localparam logic [31:0] S_LO  = scale_entry(K_VAL, 64'(WINDOW), 1'b0);
        assign w_rom_hi[g] = S_HI;
        assign w_rom_lo[g] = S_LO;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_closed) begin
                r_scale <= UNITY_Q16;
            end else if (i_single) begin
                r_scale <= w_rom_hi[i_kidx];
            end else begin
                r_scale <= w_rom_lo[i_kidx];
            end
        end
    end

    assign o_scale = r_scale;

endmodule
`default_nettype wire

/* hw/rtl/adaptive_mcmc_step_scaler.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// adaptive_mcmc_step_scaler: adaptive Metropolis step size scaler
// Counts acceptances during burn-in and rescales the active step sizes at the
// end of each window; every sampler iteration returns the active step sizes.
// ----------------------------------------------------------------------------
// A load request returns nothing. A sampler iteration takes the request,
// reads the scale table, then passes one step size per cycle, while the
// result side does not stall, through the single read port of the step
// memory, followed by the multiply and output stages. Results are beats in
// index order; each beat carries the stored (or rescaled and written back)
// step size. The next request is taken as soon as the final beat of an
// iteration sits in the output register. Step sizes must be loaded before
// they are first returned.
// ----------------------------------------------------------------------------
module adaptive_mcmc_step_scaler
    import amss_pkg::*;
#(
    parameter int WINDOW     = 64,
    parameter int MAX_PARAMS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_amss_in    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_amss_out        o_out_data,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    localparam int WC_W = $clog2(WINDOW + 1);
    localparam int KW   = $clog2(WINDOW);
    localparam int AW   = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
    localparam logic [CNT_W-1:0] CAP_N = CNT_W'((MAX_PARAMS < 16) ? MAX_PARAMS : 16);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCALE,
        S_RUN,
        S_DRAIN
    } t_state;

    t_state            r_state, n_state;
    logic [31:0]       r_burnin, n_burnin;
    logic              r_single, n_single;
    logic [4:0]        r_active, n_active;
    logic [WC_W-1:0]   r_accept, n_accept;
    logic [WC_W-1:0]   r_wpos, n_wpos;
    logic              r_closed, n_closed;
    logic [KW-1:0]     r_kidx, n_kidx;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_issue, n_issue;
    logic              r_v1, n_v1;
    logic              r_v2, n_v2;
    logic              r_out_valid, n_out_valid;
    logic [3:0]        r_idx1, n_idx1;
    logic [3:0]        r_idx2, n_idx2;
    logic              r_last1, n_last1;
    logic              r_last2, n_last2;
    logic [63:0]       r_prod, n_prod;
    t_amss_out         r_out_data, n_out_data;

    logic              w_adv;
    logic              w_in_acc;
    logic              w_in_burn;
    logic [WC_W-1:0]   w_acc_inc;
    logic [WC_W-1:0]   w_wpos_inc;
    logic              w_issue_last;
    logic [CNT_W-1:0]  w_active_n;
    logic [31:0]       w_step;
    logic [31:0]       w_rd_data;
    logic [31:0]       w_scale;
    logic              w_load_we;
    logic              w_mem_we;
    logic [AW-1:0]     w_mem_waddr;
    logic [31:0]       w_mem_wdata;

    assign o_in_ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_adv       = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign w_in_burn  = (i_in_data.chain_length >= 32'd2) &&
                        (i_in_data.chain_length <= r_burnin);
    assign w_acc_inc  = r_accept + WC_W'(i_in_data.current_first != i_in_data.previous_first);
    assign w_wpos_inc = r_wpos + WC_W'(1);

    assign w_active_n = (r_active == 5'd0) ? CNT_W'(1) :
                        ((r_active > CAP_N) ? CAP_N : r_active);
    assign w_issue_last = (r_issue == r_count - CNT_W'(1));

    // A product above 16 integer bits saturates.
    assign w_step = (r_prod[63:48] != 16'd0) ? 32'hFFFF_FFFF : r_prod[47:16];

    assign w_load_we = w_in_acc && (i_in_data.req_type == REQ_LOAD) &&
                       (32'(i_in_data.load_index) < 32'(MAX_PARAMS));
    assign w_mem_we    = w_load_we || (w_adv && r_v2);
    assign w_mem_waddr = w_load_we ? AW'(i_in_data.load_index) : AW'(r_idx2);
    assign w_mem_wdata = w_load_we ? i_in_data.load_value : w_step;

    amss_step_mem #(
        .DEPTH (MAX_PARAMS),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_adv),
        .i_raddr (AW'(r_issue)),
        .o_rdata (w_rd_data)
    );

    amss_scale_rom #(
        .WINDOW (WINDOW),
        .KW     (KW)
    ) u_rom (
        .i_clk    (i_clk),
        .i_en     (r_state == S_SCALE),
        .i_closed (r_closed),
        .i_single (r_single),
        .i_kidx   (r_kidx),
        .o_scale  (w_scale)
    );

    always_comb begin
        n_state     = r_state;
        n_burnin    = r_burnin;
        n_single    = r_single;
        n_active    = r_active;
        n_accept    = r_accept;
        n_wpos      = r_wpos;
        n_closed    = r_closed;
        n_kidx      = r_kidx;
        n_count     = r_count;
        n_issue     = r_issue;
        n_v1        = r_v1;
        n_v2        = r_v2;
        n_out_valid = r_out_valid;
        n_idx1      = r_idx1;
        n_idx2      = r_idx2;
        n_last1     = r_last1;
        n_last2     = r_last2;
        n_prod      = r_prod;
        n_out_data  = r_out_data;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BURNIN: n_burnin = i_cfg_data;
                CFG_SINGLE: n_single = i_cfg_data[0];
                CFG_ACTIVE: n_active = i_cfg_data[4:0];
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc && (i_in_data.req_type == REQ_ITER)) begin
                    n_closed = 1'b0;
                    n_kidx   = (w_acc_inc >= WC_W'(WINDOW)) ? KW'(WINDOW - 1) : KW'(w_acc_inc);
                    if (w_in_burn) begin
                        if (w_wpos_inc >= WC_W'(WINDOW)) begin
                            n_accept = '0;
                            n_wpos   = '0;
                            n_closed = 1'b1;
                        end else begin
                            n_accept = w_acc_inc;
                            n_wpos   = w_wpos_inc;
                        end
                    end
                    n_count = w_active_n;
                    n_issue = '0;
                    n_state = S_SCALE;
                end
            end
            S_SCALE: begin
                n_state = S_RUN;
            end
            S_RUN: begin
                if (w_adv) begin
                    n_issue = r_issue + CNT_W'(1);
                    if (w_issue_last) begin
                        n_state = S_DRAIN;
                    end
                end
            end
            S_DRAIN: begin
                if (w_adv && r_v2 && r_last2) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // The whole rescale pipeline moves only when the output register frees.
        if (w_adv) begin
            n_v1        = (r_state == S_RUN);
            n_idx1      = r_issue[3:0];
            n_last1     = w_issue_last;
            n_v2        = r_v1;
            n_idx2      = r_idx1;
            n_last2     = r_last1;
            n_prod      = {32'd0, w_rd_data} * {32'd0, w_scale};
            n_out_valid = r_v2;
            n_out_data  = '{param_index:   r_idx2,
                            step_size:     w_step,
                            window_closed: r_closed,
                            last:          r_last2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_burnin    <= '0;
            r_single    <= 1'b0;
            r_active    <= 5'd1;
            r_accept    <= WC_W'(1);
            r_wpos      <= WC_W'(1);
            r_closed    <= 1'b0;
            r_kidx      <= '0;
            r_count     <= CNT_W'(1);
            r_issue     <= '0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_burnin    <= n_burnin;
            r_single    <= n_single;
            r_active    <= n_active;
            r_accept    <= n_accept;
            r_wpos      <= n_wpos;
            r_closed    <= n_closed;
            r_kidx      <= n_kidx;
            r_count     <= n_count;
            r_issue     <= n_issue;
            r_v1        <= n_v1;
            r_v2        <= n_v2;
            r_out_valid <= n_out_valid;
        end
        r_idx1     <= n_idx1;
        r_idx2     <= n_idx2;
        r_last1    <= n_last1;
        r_last2    <= n_last2;
        r_prod     <= n_prod;
        r_out_data <= n_out_data;
    end

endmodule
`default_nettype wire
